### sv/lkfe_pkg.sv
// ----------------------------------------------------------------------------
// lkfe_pkg
// Shared constants, types and the key fold for the line key field extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package lkfe_pkg;

	localparam int unsigned OFFSET_WIDTH = 32;
	localparam int unsigned KEY_WIDTH    = 32;
	localparam int unsigned LOFS_WIDTH   = 32;
	localparam int unsigned BYTE_WIDTH   = 8;

	localparam logic [BYTE_WIDTH-1:0] SEP_CHAR  = 8'h3B;
	localparam logic [BYTE_WIDTH-1:0] NL_CHAR   = 8'h0A;
	localparam logic [KEY_WIDTH-1:0]  ZERO_CHAR = 32'd48;
	localparam logic [KEY_WIDTH-1:0]  RADIX     = 32'd10;

	typedef struct packed {
		logic                        emit;
		logic signed [KEY_WIDTH-1:0] key_value;
		logic [LOFS_WIDTH-1:0]       line_offset;
	} result_t;

	// key*10 + (signed byte - '0'), wrapping
	function automatic logic [KEY_WIDTH-1:0] fold_key(
		input logic [KEY_WIDTH-1:0]  key,
		input logic [BYTE_WIDTH-1:0] b
	);
		logic [KEY_WIDTH-1:0] sb;
		sb = {{(KEY_WIDTH-BYTE_WIDTH){b[BYTE_WIDTH-1]}}, b};
		return KEY_WIDTH'(key * RADIX) + sb - ZERO_CHAR;
	endfunction

endpackage

`default_nettype wire

### sv/lkfe_if.sv
// ----------------------------------------------------------------------------
// lkfe interfaces
// Valid/ready channels for text bytes in and line keys out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkfe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;

	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface lkfe_key_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] key_value;
	logic [31:0]        line_offset;

	modport source (output valid, output key_value, output line_offset, input ready);
	modport sink   (input valid, input key_value, input line_offset, output ready);
endinterface

`default_nettype wire

### sv/lkfe_parser.sv
// ----------------------------------------------------------------------------
// lkfe_parser
// Per-line field state: seeks the first separator, folds the key up to the
// second, tracks the byte position and the start of the current line.
// ----------------------------------------------------------------------------
`default_nettype none

module lkfe_parser #(
	parameter int unsigned OFFSET_WIDTH = lkfe_pkg::OFFSET_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 take,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 end_of_data,
	output lkfe_pkg::result_t         result
);

	typedef enum logic [1:0] {
		PH_SEEK = 2'd0,
		PH_FOLD = 2'd1,
		PH_SKIP = 2'd2
	} phase_t;

	phase_t                                  phase_q, phase_d;
	logic [lkfe_pkg::KEY_WIDTH-1:0]          key_q, key_d;
	logic [OFFSET_WIDTH-1:0]                 start_q;
	logic [OFFSET_WIDTH-1:0]                 pos_q, pos_nx;
	logic                                    is_nl;
	logic                                    is_sep;

	assign is_nl  = (data_byte == lkfe_pkg::NL_CHAR);
	assign is_sep = (data_byte == lkfe_pkg::SEP_CHAR);
	assign pos_nx = pos_q + OFFSET_WIDTH'(1);

	always_comb begin
		phase_d = phase_q;
		key_d   = key_q;
		if (!is_nl) begin
			case (phase_q)
				PH_SEEK: begin
					if (is_sep)
						phase_d = PH_FOLD;
				end
				PH_FOLD: begin
					if (is_sep)
						phase_d = PH_SKIP;
					else
						key_d = lkfe_pkg::fold_key(key_q, data_byte);
				end
				default: ;
			endcase
		end
	end

	assign result.emit        = is_nl || end_of_data;
	assign result.key_value   = key_d;
	assign result.line_offset = lkfe_pkg::LOFS_WIDTH'(start_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			key_q   <= '0;
			start_q <= '0;
			pos_q   <= '0;
		end else if (take) begin
			if (end_of_data) begin
				phase_q <= PH_SEEK;
				key_q   <= '0;
				start_q <= '0;
				pos_q   <= '0;
			end else if (is_nl) begin
				phase_q <= PH_SEEK;
				key_q   <= '0;
				start_q <= pos_nx;
				pos_q   <= pos_nx;
			end else begin
				phase_q <= phase_d;
				key_q   <= key_d;
				pos_q   <= pos_nx;
			end
		end
	end

	a_eod_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && end_of_data |=> pos_q == '0 && start_q == '0 && key_q == '0)
		else $error("state not cleared after last byte");

	a_nl_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_nl && !end_of_data |=> start_q == pos_q && phase_q == PH_SEEK)
		else $error("line start not set after newline");

	a_key_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEEK |-> key_q == '0)
		else $error("key non-zero before first separator");

endmodule

`default_nettype wire

### sv/line_key_field_extractor.sv
// ----------------------------------------------------------------------------
// line_key_field_extractor
// Parses semicolon-delimited text one byte per cycle and emits, per line,
// the decimal key of the second field and the offset where the line began.
//
//   channel | dir | payload                        | request
//   rx      | in  | data_byte[7:0], end_of_data    | one text byte
//   tx      | out | key_value[31:0], line_offset   | one line key
//
// One byte per cycle sustained while rx.ready is high. A result taken with the
// newline or last byte is registered into the output register, or into the
// skid entry while tx is stalled; this two-entry buffer lets rx keep flowing
// while tx is stalled for one request. rx.ready drops only while the skid
// entry is occupied. arst_n clears parser state and empties both buffer entries.
// ----------------------------------------------------------------------------
`default_nettype none

module line_key_field_extractor #(
	parameter int unsigned OFFSET_WIDTH = lkfe_pkg::OFFSET_WIDTH
) (
	input wire logic    clk,
	input wire logic    arst_n,
	lkfe_byte_if.sink   rx,
	lkfe_key_if.source  tx
);

	lkfe_pkg::result_t res;
	lkfe_pkg::result_t out_q;
	lkfe_pkg::result_t skid_q;
	logic              out_v_q;
	logic              skid_v_q;
	logic              take;
	logic              push;
	logic              out_free;

	assign rx.ready = !skid_v_q;
	assign take     = rx.valid && rx.ready;
	assign push     = take && res.emit;
	assign out_free = !out_v_q || tx.ready;

	lkfe_parser #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.data_byte   (rx.data_byte),
		.end_of_data (rx.end_of_data),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (push)
				out_q <= res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign tx.valid       = out_v_q;
	assign tx.key_value   = out_q.key_value;
	assign tx.line_offset = out_q.line_offset;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held with empty output register");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		push && out_v_q && !tx.ready |=> skid_v_q)
		else $error("result lost under stall");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && tx.ready |=> out_v_q && !skid_v_q && $past(skid_q) == out_q)
		else $error("skid entry not moved to output register");

endmodule

`default_nettype wire

### tb/line_key_field_extractor_tb.sv
// ----------------------------------------------------------------------------
// line_key_field_extractor_tb
// Drives text bytes into the line key field extractor and checks every line
// key request against a cycle-free parser of its own, typed rows against
// the table. A short table of directed bytes comes first, then random lines,
// mostly well formed, with random pacing and back-pressure on both channels.
// ----------------------------------------------------------------------------
module line_key_field_extractor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BYTE_TARGET  = 1750;
	localparam int STALL_LIMIT  = 4000;
	localparam int LONG_HOLD    = 300;
	localparam int MAX_PACE     = 16;
	localparam int DRAIN_CYCLES = 8;

	typedef enum logic [1:0] {
		SEEK_SEP = 2'd0,
		FOLD_KEY = 2'd1,
		PAST_KEY = 2'd2
	} phase_e;

	typedef struct packed {
		logic signed [lkfe_pkg::KEY_WIDTH-1:0] key_value;
		logic [lkfe_pkg::LOFS_WIDTH-1:0]       line_offset;
	} line_key_t;

	typedef struct packed {
		logic [lkfe_pkg::BYTE_WIDTH-1:0] data_byte;
		logic                            end_of_data;
		logic                            typed;
		line_key_t                       res;
	} opening_row_t;

	localparam int N_OPENING = 22;
	localparam opening_row_t OPENING_ROWS [N_OPENING] = '{
		'{8'h0A, 1'b0, 1'b1, '{32'sd0, 32'd0}},
		'{8'h00, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h3B, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'hFF, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h80, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h7F, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h3B, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h35, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h0A, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h3B, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h31, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h32, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h0A, 1'b0, 1'b1, '{32'sd12, 32'd9}},
		'{8'h37, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h37, 1'b1, 1'b1, '{32'sd0, 32'd13}},
		'{8'h3B, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h34, 1'b1, 1'b1, '{32'sd4, 32'd0}},
		'{8'h0A, 1'b1, 1'b1, '{32'sd0, 32'd0}},
		'{8'h3B, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h3B, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h39, 1'b0, 1'b0, '{32'sd0, 32'd0}},
		'{8'h0A, 1'b0, 1'b1, '{32'sd0, 32'd0}}
	};

	logic clk;
	logic arst_n;

	lkfe_byte_if rx_ch ();
	lkfe_key_if  tx_ch ();

	line_key_field_extractor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	phase_e                            mdl_phase;
	logic [lkfe_pkg::KEY_WIDTH-1:0]    mdl_key;
	logic [lkfe_pkg::OFFSET_WIDTH-1:0] mdl_line_start;
	logic [lkfe_pkg::OFFSET_WIDTH-1:0] mdl_pos;

	line_key_t line_keys_due [$];
	int        fault_count;
	int        bytes_sent;
	bit        byte_pace_busy;
	bit        key_pace_busy;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void log_fault(string what);
		fault_count++;
		if (fault_count <= 10)
			$display("mismatch: %s", what);
	endfunction

	// one byte through the line parser; returns 1 when a line key is due
	function automatic bit parse_byte(input logic [lkfe_pkg::BYTE_WIDTH-1:0] b,
		input logic eod, output line_key_t res);
		logic [lkfe_pkg::KEY_WIDTH-1:0] sb;
		bit                             emit;
		emit = eod || (b == lkfe_pkg::NL_CHAR);
		if (b != lkfe_pkg::NL_CHAR) begin
			case (mdl_phase)
				SEEK_SEP: begin
					if (b == lkfe_pkg::SEP_CHAR)
						mdl_phase = FOLD_KEY;
				end
				FOLD_KEY: begin
					if (b == lkfe_pkg::SEP_CHAR) begin
						mdl_phase = PAST_KEY;
					end else begin
						sb = {{(lkfe_pkg::KEY_WIDTH-lkfe_pkg::BYTE_WIDTH){
							b[lkfe_pkg::BYTE_WIDTH-1]}}, b};
						mdl_key = mdl_key * lkfe_pkg::RADIX + sb - lkfe_pkg::ZERO_CHAR;
					end
				end
				default: ;
			endcase
		end
		mdl_pos = mdl_pos + 1'b1;
		res.key_value = mdl_key;
		res.line_offset = mdl_line_start[lkfe_pkg::LOFS_WIDTH-1:0];
		if (emit) begin
			mdl_phase = SEEK_SEP;
			mdl_key = '0;
			if (eod) begin
				mdl_pos = '0;
				mdl_line_start = '0;
			end else begin
				mdl_line_start = mdl_pos;
			end
		end
		return emit;
	endfunction

	function automatic int draw_pace(inout bit busy);
		if ($urandom_range(0, 31) == 0)
			busy = !busy;
		return busy ? $urandom_range(0, MAX_PACE) : 0;
	endfunction

	function automatic logic [lkfe_pkg::BYTE_WIDTH-1:0] plain_byte();
		logic [lkfe_pkg::BYTE_WIDTH-1:0] d;
		do
			d = lkfe_pkg::BYTE_WIDTH'($urandom_range(0, 255));
		while (d == lkfe_pkg::SEP_CHAR || d == lkfe_pkg::NL_CHAR);
		return d;
	endfunction

	task automatic push_byte(input logic [lkfe_pkg::BYTE_WIDTH-1:0] b, input logic eod,
		input logic typed, input line_key_t typed_res);
		int        gap;
		line_key_t res;
		gap = draw_pace(byte_pace_busy);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.data_byte <= b;
		rx_ch.end_of_data <= eod;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
		if (parse_byte(b, eod, res) && !typed)
			line_keys_due.push_back(res);
		if (typed)
			line_keys_due.push_back(typed_res);
	endtask

	task automatic send_line();
		int                              n_pre;
		int                              n_dig;
		int                              n_tail;
		int                              k;
		logic [lkfe_pkg::BYTE_WIDTH-1:0] d;
		if ($urandom_range(0, 9) == 0) begin
			n_pre = $urandom_range(1, 8);
			for (k = 0; k < n_pre; k++)
				push_byte(lkfe_pkg::BYTE_WIDTH'($urandom_range(0, 255)),
					$urandom_range(0, 63) == 0, 1'b0, '0);
			return;
		end
		n_pre = $urandom_range(0, 3);
		for (k = 0; k < n_pre; k++)
			push_byte(plain_byte(), 1'b0, 1'b0, '0);
		if ($urandom_range(0, 9) != 0) begin
			push_byte(lkfe_pkg::SEP_CHAR, 1'b0, 1'b0, '0);
			n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 5);
			for (k = 0; k < n_dig; k++) begin
				d = ($urandom_range(0, 9) == 0) ? plain_byte()
					: lkfe_pkg::BYTE_WIDTH'(lkfe_pkg::ZERO_CHAR + $urandom_range(0, 9));
				push_byte(d, 1'b0, 1'b0, '0);
			end
			if ($urandom_range(0, 4) != 0) begin
				push_byte(lkfe_pkg::SEP_CHAR, 1'b0, 1'b0, '0);
				n_tail = $urandom_range(0, 3);
				for (k = 0; k < n_tail; k++)
					push_byte(($urandom_range(0, 3) == 0) ? lkfe_pkg::SEP_CHAR : plain_byte(),
						1'b0, 1'b0, '0);
			end
		end
		case ($urandom_range(0, 19))
			0:       push_byte(plain_byte(), 1'b1, 1'b0, '0);
			1:       push_byte(lkfe_pkg::NL_CHAR, 1'b1, 1'b0, '0);
			default: push_byte(lkfe_pkg::NL_CHAR, 1'b0, 1'b0, '0);
		endcase
	endtask

	task automatic settle_all_keys();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (line_keys_due.size() != 0) @(posedge clk);
	endtask

	initial begin : key_sink
		int        hold;
		int        n_keys;
		line_key_t due;
		n_keys = 0;
		tx_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (n_keys == 20 || n_keys == 120)
				hold = LONG_HOLD;
			else
				hold = draw_pace(key_pace_busy);
			if (hold > 0) begin
				tx_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			tx_ch.ready <= 1'b1;
			do @(posedge clk); while (!tx_ch.valid);
			n_keys++;
			if (line_keys_due.size() == 0) begin
				log_fault($sformatf("unexpected request key=%0d offset=%0d",
					tx_ch.key_value, tx_ch.line_offset));
			end else begin
				due = line_keys_due.pop_front();
				if (tx_ch.key_value !== due.key_value)
					log_fault($sformatf("key_value exp %0d got %0d (offset %0d)",
						due.key_value, tx_ch.key_value, due.line_offset));
				if (tx_ch.line_offset !== due.line_offset)
					log_fault($sformatf("line_offset exp %0d got %0d",
						due.line_offset, tx_ch.line_offset));
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : byte_source
		int  r;
		bit  paused;
		fault_count = 0;
		bytes_sent = 0;
		byte_pace_busy = 1'b0;
		key_pace_busy = 1'b1;
		paused = 1'b0;
		mdl_phase = SEEK_SEP;
		mdl_key = '0;
		mdl_line_start = '0;
		mdl_pos = '0;
		arst_n <= 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.data_byte <= '0;
		rx_ch.end_of_data <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < N_OPENING; r++)
			push_byte(OPENING_ROWS[r].data_byte, OPENING_ROWS[r].end_of_data,
				OPENING_ROWS[r].typed, OPENING_ROWS[r].res);
		settle_all_keys();

		while (bytes_sent < N_OPENING + BYTE_TARGET) begin
			send_line();
			if (!paused && bytes_sent > N_OPENING + BYTE_TARGET / 2) begin
				paused = 1'b1;
				settle_all_keys();
			end
		end

		settle_all_keys();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### line_key_field_extractor.f
sv/lkfe_pkg.sv
sv/lkfe_if.sv
sv/lkfe_parser.sv
sv/line_key_field_extractor.sv
tb/line_key_field_extractor_tb.sv
